/* hdl/shamh_pkg.sv */
// Shared types and constants for the SHA-256 message hasher.
// Holds the controller states, datapath command struct and the round tables.
// No dependencies.
package shamh_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 61;
    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned ROUNDS  = 64;
    localparam int unsigned HWORDS  = 8;

    localparam int unsigned FILL_W  = 6;
    localparam int unsigned ROUND_W = 6;
    localparam int unsigned WIDX_W  = 3;

    localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
    localparam logic [FILL_W-1:0]  FILL_LEN   = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [WIDX_W-1:0]  WORD_LAST  = 3'd7;

    localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;

    localparam logic [WORD_W-1:0] K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] HASH_INIT [HWORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_FINAL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    typedef struct packed {
        logic               shift_en;
        t_src               byte_src;
        logic               cnt_inc;
        logic               load_work;
        logic               round_en;
        logic               add_hash;
        logic               rearm;
        logic [ROUND_W-1:0] round_idx;
        logic [WIDX_W-1:0]  len_idx;
        logic [WIDX_W-1:0]  out_idx;
    } t_cmd;

endpackage

/* hdl/shamh_datapath.sv */
// Datapath of the SHA-256 message hasher: block/schedule shift line,
// round variables, hash state and byte count. Driven by shamh_ctrl.
// Depends on shamh_pkg.
module shamh_datapath import shamh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic [WORD_W-1:0] o_digest_word
);

    // word k of the window sits at bits [BLOCK_W-1-WORD_W*k -: WORD_W]
    localparam int unsigned W0_HI  = BLOCK_W - 1;
    localparam int unsigned W1_HI  = BLOCK_W - 1 - WORD_W;
    localparam int unsigned W9_HI  = BLOCK_W - 1 - 9 * WORD_W;
    localparam int unsigned W14_HI = BLOCK_W - 1 - 14 * WORD_W;

    logic [BLOCK_W-1:0] r_win,   n_win;
    logic [WORD_W-1:0]  r_hash [HWORDS];
    logic [WORD_W-1:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [COUNT_W-1:0] r_count;

    logic [63:0]        bit_len;
    logic [5:0]         len_shift;
    logic [BYTE_W-1:0]  shift_byte;
    logic [WORD_W-1:0]  w0, w1, w9, w14, w_next;
    logic [WORD_W-1:0]  t1, t2;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] small0(input logic [WORD_W-1:0] x);
        small0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small1(input logic [WORD_W-1:0] x);
        small1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] big0(input logic [WORD_W-1:0] x);
        big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big1(input logic [WORD_W-1:0] x);
        big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // length field, big-endian: byte j of the eight is bits [63-8j -: 8]
    assign bit_len   = {r_count, 3'b000};
    assign len_shift = {~i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.byte_src)
            SRC_IN:   shift_byte = i_data_byte;
            SRC_PAD:  shift_byte = PAD_BYTE;
            SRC_ZERO: shift_byte = '0;
            SRC_LEN:  shift_byte = bit_len[len_shift +: BYTE_W];
            default:  shift_byte = '0;
        endcase
    end

    assign w0  = r_win[W0_HI  -: WORD_W];
    assign w1  = r_win[W1_HI  -: WORD_W];
    assign w9  = r_win[W9_HI  -: WORD_W];
    assign w14 = r_win[W14_HI -: WORD_W];

    // W[t+16] from the window that holds W[t..t+15]
    assign w_next = small1(w14) + w9 + small0(w1) + w0;

    assign t1 = r_h + big1(r_e) + ((r_e & r_f) ^ (~r_e & r_g))
              + K_ROUND[i_cmd.round_idx] + w0;
    assign t2 = big0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    always_comb begin
        n_win = r_win;
        if (i_cmd.shift_en) begin
            n_win = {r_win[BLOCK_W-BYTE_W-1:0], shift_byte};
        end else if (i_cmd.round_en) begin
            n_win = {r_win[BLOCK_W-WORD_W-1:0], w_next};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (i_cmd.load_work) begin
            r_a <= r_hash[0];
            r_b <= r_hash[1];
            r_c <= r_hash[2];
            r_d <= r_hash[3];
            r_e <= r_hash[4];
            r_f <= r_hash[5];
            r_g <= r_hash[6];
            r_h <= r_hash[7];
        end else if (i_cmd.round_en) begin
            r_a <= t1 + t2;
            r_b <= r_a;
            r_c <= r_b;
            r_d <= r_c;
            r_e <= r_d + t1;
            r_f <= r_e;
            r_g <= r_f;
            r_h <= r_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rearm) begin
            r_hash  <= HASH_INIT;
            r_count <= '0;
        end else begin
            if (i_cmd.add_hash) begin
                r_hash[0] <= r_hash[0] + r_a;
                r_hash[1] <= r_hash[1] + r_b;
                r_hash[2] <= r_hash[2] + r_c;
                r_hash[3] <= r_hash[3] + r_d;
                r_hash[4] <= r_hash[4] + r_e;
                r_hash[5] <= r_hash[5] + r_f;
                r_hash[6] <= r_hash[6] + r_g;
                r_hash[7] <= r_hash[7] + r_h;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_digest_word = r_hash[i_cmd.out_idx];

endmodule

/* hdl/shamh_ctrl.sv */
// Controller of the SHA-256 message hasher: sequences byte intake,
// padding, the 64 rounds of each block and the digest readout.
// Depends on shamh_pkg.
module shamh_ctrl import shamh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_has_data,
    input  logic i_message_end,
    output logic o_valid,
    input  logic i_ready,
    output logic o_last,
    output t_cmd o_cmd
);

    t_state              r_state, n_state;
    t_state              r_ret,   n_ret;
    logic [FILL_W-1:0]   r_fill,  n_fill;
    logic [ROUND_W-1:0]  r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_round = r_round;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_last  = 1'b0;
        o_cmd           = '0;
        o_cmd.byte_src  = SRC_IN;
        o_cmd.round_idx = r_round;
        o_cmd.len_idx   = r_fill[WIDX_W-1:0];
        o_cmd.out_idx   = r_round[WIDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_has_data) begin
                        o_cmd.shift_en = 1'b1;
                        o_cmd.cnt_inc  = 1'b1;
                        n_fill = r_fill + 1'b1;
                        if (r_fill == FILL_LAST) begin
                            n_state = S_LOAD;
                            n_ret   = i_message_end ? S_PAD : S_IDLE;
                        end else if (i_message_end) begin
                            n_state = S_PAD;
                        end
                    end else if (i_message_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_en = 1'b1;
                o_cmd.byte_src = SRC_PAD;
                n_fill = r_fill + 1'b1;
                n_state = S_ZERO;
                if (r_fill == FILL_LAST) begin
                    n_state = S_LOAD;
                    n_ret   = S_ZERO;
                end
            end
            S_ZERO: begin
                // zero fill up to the length field, through a full block if needed
                if (r_fill == FILL_LEN) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.shift_en = 1'b1;
                    o_cmd.byte_src = SRC_ZERO;
                    n_fill = r_fill + 1'b1;
                    if (r_fill == FILL_LAST) begin
                        n_state = S_LOAD;
                        n_ret   = S_ZERO;
                    end
                end
            end
            S_LEN: begin
                o_cmd.shift_en = 1'b1;
                o_cmd.byte_src = SRC_LEN;
                n_fill = r_fill + 1'b1;
                if (r_fill == FILL_LAST) begin
                    n_state = S_LOAD;
                    n_ret   = S_OUT;
                end
            end
            S_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.add_hash = 1'b1;
                n_round = '0;
                n_state = r_ret;
            end
            S_OUT: begin
                o_valid = 1'b1;
                o_last  = (r_round[WIDX_W-1:0] == WORD_LAST);
                if (i_ready) begin
                    n_round = r_round + 1'b1;
                    if (o_last) begin
                        // re-arm for the next message
                        o_cmd.rearm = 1'b1;
                        n_round = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/sha256_message_hasher_unit.sv */
// Top level of the SHA-256 message hasher: shamh_ctrl and shamh_datapath, on shamh_pkg.
// A byte item is taken while o_ready is high; the item that fills a block starts a
// compression (load, 64 rounds at one per cycle, hash update) with o_ready low.
// End item: pad byte, zero fill to the length field and eight length bytes, plus one or
// two block compressions, then eight digest words, one per cycle while i_ready is high.
// Reset is synchronous, active low: loads the initial hash and clears the byte count.
module sha256_message_hasher_unit import shamh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_has_data,
    input  logic              i_message_end,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_digest_word,
    output logic              o_digest_last
);

    t_cmd cmd;

    shamh_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_has_data    (i_has_data),
        .i_message_end (i_message_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_last        (o_digest_last),
        .o_cmd         (cmd)
    );

    shamh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_digest_word (o_digest_word)
    );

endmodule

/* test/tb.sv */
// Testbench for sha256_message_hasher_unit: feeds byte messages of assorted lengths
// and checks every digest word against a SHA-256 model kept in the bench.
// Depends on shamh_pkg (port widths) and the unit itself; needs no other files.
module tb import shamh_pkg::*;;

    localparam int unsigned RANDOM_ITEMS = 340;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    localparam logic [WORD_W-1:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_digest_beat;

    typedef enum int unsigned {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE
    } t_rdy_mode;

    class sha_digest_board;
        logic [WORD_W-1:0]  chain [8];
        logic [BYTE_W-1:0]  blk_bytes [64];
        logic [COUNT_W-1:0] byte_cnt;
        t_digest_beat       digest_q [$];
        int unsigned        fails;

        function new();
            fails = 0;
            rearm();
        endfunction

        function void rearm();
            chain    = IV_WORDS;
            byte_cnt = '0;
        endfunction

        function logic [WORD_W-1:0] rotr(logic [WORD_W-1:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // Fold the 64-byte buffer into the chaining value.
        function void absorb_block();
            logic [WORD_W-1:0] sched [64];
            logic [WORD_W-1:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
            for (int r = 0; r < 16; r++) begin
                sched[r] = {blk_bytes[4*r], blk_bytes[4*r+1],
                            blk_bytes[4*r+2], blk_bytes[4*r+3]};
            end
            for (int r = 16; r < 64; r++) begin
                s0 = rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3);
                s1 = rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10);
                sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int r = 0; r < 64; r++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + RND_K[r] + sched[r];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void take_item(logic [BYTE_W-1:0] data, logic has_data, logic msg_end);
            logic [5:0]  pos;
            logic [63:0] bit_len;
            if (has_data) begin
                blk_bytes[byte_cnt[5:0]] = data;
                byte_cnt = byte_cnt + 1'b1;
                if (byte_cnt[5:0] == 6'd0) absorb_block();
            end
            if (!msg_end) return;
            pos = byte_cnt[5:0];
            blk_bytes[pos] = PAD_MARK;
            for (int k = pos + 1; k < 64; k++) blk_bytes[k] = '0;
            // No room for the length: spill into an extra block.
            if (pos >= 56) begin
                absorb_block();
                foreach (blk_bytes[k]) blk_bytes[k] = '0;
            end
            bit_len = {byte_cnt, 3'b000};
            for (int k = 0; k < 8; k++) blk_bytes[56+k] = bit_len[63-8*k -: 8];
            absorb_block();
            for (int k = 0; k < 8; k++) digest_q.push_back({chain[k], k == 7});
            rearm();
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            fails++;
        endtask

        task check_word(logic [WORD_W-1:0] word, logic last);
            t_digest_beat want;
            if (digest_q.size() == 0) begin
                report($sformatf("digest word %h with none pending", word));
                return;
            end
            want = digest_q.pop_front();
            if (word !== want.word)
                report($sformatf("digest_word %h, want %h", word, want.word));
            if (last !== want.last)
                report($sformatf("digest_last %b, want %b", last, want.last));
        endtask

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [BYTE_W-1:0] i_data_byte   = '0;
    logic              i_has_data    = 1'b0;
    logic              i_message_end = 1'b0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [WORD_W-1:0] o_digest_word;
    logic              o_digest_last;

    sha_digest_board sb;
    int unsigned     burst_left = 0;
    int unsigned     items_sent = 0;
    int unsigned     cycle_cnt  = 0;
    int unsigned     mode_cnt   = 0;
    t_rdy_mode       ready_mode = RDY_ALWAYS;

    sha256_message_hasher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_has_data    (i_has_data),
        .i_message_end (i_message_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_digest_last (o_digest_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Check accepted digest words and stall the result side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_word(o_digest_word, o_digest_last);
        if (mode_cnt == 0) begin
            mode_cnt   = $urandom_range(8, 80);
            ready_mode = t_rdy_mode'($urandom_range(0, 2));
        end
        mode_cnt--;
        case (ready_mode)
            RDY_ALWAYS: i_ready <= 1'b1;
            RDY_COIN:   i_ready <= 1'($urandom_range(0, 1));
            default:    i_ready <= (mode_cnt % 4 == 0);
        endcase
    end

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input logic [BYTE_W-1:0] data, input logic has_data,
                             input logic msg_end);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap != 0) begin
            i_valid       <= 1'b0;
            i_data_byte   <= 8'($urandom);
            i_has_data    <= 1'($urandom);
            i_message_end <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= data;
        i_has_data    <= has_data;
        i_message_end <= msg_end;
        do @(posedge i_clk); while (!o_ready);
        sb.take_item(data, has_data, msg_end);
    endtask

    // Send len bytes; close either on the last byte or with a separate empty end item.
    task automatic send_message(input int unsigned len, input bit end_on_byte,
                                input int unsigned noise_odds);
        bit close_here;
        for (int unsigned n = 0; n < len; n++) begin
            if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1) begin
                send_item(8'($urandom), 1'b0, 1'b0);
                items_sent++;
            end
            close_here = end_on_byte && (n == len - 1);
            send_item(8'($urandom), 1'b1, close_here);
            items_sent++;
        end
        if (!end_on_byte || len == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    initial begin
        int unsigned len;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, alone and after an ignored item.
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // Single-byte messages at the byte extremes.
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        // "abc" closed on its last byte, then closed by an empty end item.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // Alternating bit patterns with an ignored item in the middle.
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0, 1:    len = $urandom_range(0, 4);
                2:       len = $urandom_range(55, 57);
                3:       len = $urandom_range(63, 65);
                4:       len = ($urandom_range(0, 2) == 0) ? $urandom_range(118, 128)
                                                           : $urandom_range(5, 30);
                default: len = $urandom_range(5, 40);
            endcase
            send_message(len, 1'($urandom), ($urandom_range(0, 2) == 0) ? 0 : 12);
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

/* sim.f */
hdl/shamh_pkg.sv
hdl/shamh_datapath.sv
hdl/shamh_ctrl.sv
hdl/sha256_message_hasher_unit.sv
test/tb.sv
